// ----- rtl/core/ihp_pkg.sv -----
// Shared types and constants of the IPv4 header parser.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package ihp_pkg;

	localparam int BaseHeaderBytes   = 20;
	localparam int DefMaxOptionBytes = 40;
	localparam int SumWidth          = 21;

	localparam logic [3:0] IpVersion = 4'd4;
	localparam logic [3:0] IhlMask   = 4'b1111;

	typedef enum logic [1:0] {
		StatusOk         = 2'd0,
		StatusBadVersion = 2'd1,
		StatusBadLength  = 2'd2
	} ihp_status_t;

	typedef struct packed {
		logic [7:0] header_byte;
		logic       first_byte;
	} ihp_item_t;

	typedef struct packed {
		ihp_status_t status;
		logic [5:0]  header_length;
		logic [7:0]  dscp_ecn;
		logic [15:0] packet_length;
		logic [15:0] ident_field;
		logic [15:0] flags_offset;
		logic [7:0]  hop_limit;
		logic [7:0]  proto_number;
		logic [15:0] carried_checksum;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] checksum_result;
	} ihp_result_t;

endpackage

// ----- rtl/core/ihp_in_if.sv -----
// Valid/ready channel that carries header bytes into the parser.
// Depends on ihp_pkg for the item type.
`timescale 1ns / 1ps

interface ihp_in_if;
	import ihp_pkg::*;

	logic      valid;
	logic      ready;
	ihp_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/ihp_out_if.sv -----
// Valid/ready channel that carries parse results out of the block.
// Depends on ihp_pkg for the result type.
`timescale 1ns / 1ps

interface ihp_out_if;
	import ihp_pkg::*;

	logic        valid;
	logic        ready;
	ihp_result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/ihp_parse.sv -----
// Input register, header state and field capture with the running word sum.
// Depends on ihp_pkg and ihp_in_if; produces at most one result per byte.
`timescale 1ns / 1ps

module ihp_parse #(
	parameter int MAX_OPTION_BYTES = ihp_pkg::DefMaxOptionBytes
) (
	input  logic                clk,
	input  logic                arst_n,
	ihp_in_if.sink              hdr_in,
	output logic                res_valid,
	output ihp_pkg::ihp_result_t res,
	input  logic                res_room
);
	import ihp_pkg::*;

	localparam int MaxLen = BaseHeaderBytes + MAX_OPTION_BYTES;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       first_s1;
	logic       advance;

	logic [5:0]          pos_q, pos_d;
	logic [5:0]          exp_len_q, exp_len_d;
	logic                skip_q, skip_d;
	logic [SumWidth-1:0] sum_q, sum_d;
	logic [7:0]          high_q, high_d;
	logic [7:0]          dscp_q, dscp_d;
	logic [15:0]         length_q, length_d;
	logic [15:0]         ident_q, ident_d;
	logic [15:0]         frag_q, frag_d;
	logic [7:0]          ttl_q, ttl_d;
	logic [7:0]          proto_q, proto_d;
	logic [15:0]         cksum_q, cksum_d;
	logic [31:0]         src_q, src_d;
	logic [31:0]         dst_q, dst_d;

	logic [3:0]          version;
	logic [5:0]          len;
	logic                bad_ver;
	logic                bad_len;
	logic                last;
	logic [SumWidth-1:0] sum_word;
	logic [16:0]         fold1;
	logic [15:0]         fold2;

	// The staged byte moves on unless it has a result and the output is full.
	assign advance      = valid_s1 && (!res_valid || res_room);
	assign hdr_in.ready = !valid_s1 || !res_valid || res_room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (hdr_in.ready) begin
			valid_s1 <= hdr_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (hdr_in.ready && hdr_in.valid) begin
			byte_s1  <= hdr_in.data.header_byte;
			first_s1 <= hdr_in.data.first_byte;
		end
	end

	assign version = byte_s1[7:4];
	assign len     = {byte_s1[3:0] & IhlMask, 2'b00};
	assign bad_ver = version != IpVersion;
	assign bad_len = (int'(len) < BaseHeaderBytes) || (int'(len) > MaxLen);
	assign last    = ({1'b0, pos_q} + 7'd1) >= {1'b0, exp_len_q};

	// The last byte of a header sits at an odd position, so its word completes the sum.
	assign sum_word = sum_q + SumWidth'({high_q, byte_s1});

	// Two end-around folds bring the wide sum down to 16 bits.
	assign fold1 = {1'b0, sum_word[15:0]} + 17'(sum_word[SumWidth-1:16]);
	assign fold2 = fold1[15:0] + 16'(fold1[16]);

	always_comb begin
		pos_d     = pos_q;
		exp_len_d = exp_len_q;
		skip_d    = skip_q;
		sum_d     = sum_q;
		high_d    = high_q;
		dscp_d    = dscp_q;
		length_d  = length_q;
		ident_d   = ident_q;
		frag_d    = frag_q;
		ttl_d     = ttl_q;
		proto_d   = proto_q;
		cksum_d   = cksum_q;
		src_d     = src_q;
		dst_d     = dst_q;
		res_valid = 1'b0;
		res       = '0;
		if (valid_s1) begin
			if (first_s1) begin
				if (bad_ver || bad_len) begin
					skip_d            = 1'b1;
					pos_d             = '0;
					res_valid         = 1'b1;
					res.status        = bad_ver ? StatusBadVersion : StatusBadLength;
					res.header_length = len;
				end else begin
					skip_d    = 1'b0;
					exp_len_d = len;
					pos_d     = 6'd1;
					high_d    = byte_s1;
					sum_d     = '0;
				end
			end else if (!skip_q) begin
				// Even positions hold the high byte; odd positions complete a word.
				if (!pos_q[0]) begin
					high_d = byte_s1;
				end else begin
					sum_d = sum_word;
				end
				unique case (pos_q)
					6'd1: dscp_d = byte_s1;
					6'd2, 6'd3: length_d = {length_q[7:0], byte_s1};
					6'd4, 6'd5: ident_d = {ident_q[7:0], byte_s1};
					6'd6, 6'd7: frag_d = {frag_q[7:0], byte_s1};
					6'd8: ttl_d = byte_s1;
					6'd9: proto_d = byte_s1;
					6'd10, 6'd11: cksum_d = {cksum_q[7:0], byte_s1};
					6'd12, 6'd13, 6'd14, 6'd15: src_d = {src_q[23:0], byte_s1};
					6'd16, 6'd17, 6'd18, 6'd19: dst_d = {dst_q[23:0], byte_s1};
					default: ;
				endcase
				if (last) begin
					skip_d                = 1'b1;
					pos_d                 = '0;
					res_valid             = 1'b1;
					res.status            = StatusOk;
					res.header_length     = exp_len_q;
					res.dscp_ecn          = dscp_d;
					res.packet_length     = length_d;
					res.ident_field       = ident_d;
					res.flags_offset      = frag_d;
					res.hop_limit         = ttl_d;
					res.proto_number      = proto_d;
					res.carried_checksum  = cksum_d;
					res.src_addr          = src_d;
					res.dst_addr          = dst_d;
					res.checksum_result   = ~fold2;
				end else begin
					pos_d = pos_q + 6'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			exp_len_q <= '0;
			skip_q    <= 1'b1;
			sum_q     <= '0;
			high_q    <= '0;
		end else if (advance) begin
			pos_q     <= pos_d;
			exp_len_q <= exp_len_d;
			skip_q    <= skip_d;
			sum_q     <= sum_d;
			high_q    <= high_d;
		end
	end

	// Every field store is rewritten before a header can finish, so no reset.
	always_ff @(posedge clk) begin
		if (advance) begin
			dscp_q   <= dscp_d;
			length_q <= length_d;
			ident_q  <= ident_d;
			frag_q   <= frag_d;
			ttl_q    <= ttl_d;
			proto_q  <= proto_d;
			cksum_q  <= cksum_d;
			src_q    <= src_d;
			dst_q    <= dst_d;
		end
	end

`ifndef SYNTHESIS
	a_pos_in_header: assert property (@(posedge clk) disable iff (!arst_n)
		!skip_q |-> (pos_q != 6'd0) && (pos_q < exp_len_q))
		else $error("byte position outside the header in progress");

	a_len_legal: assert property (@(posedge clk) disable iff (!arst_n)
		!skip_q |-> (int'(exp_len_q) >= BaseHeaderBytes) && (int'(exp_len_q) <= MaxLen)
			&& (exp_len_q[1:0] == 2'b00))
		else $error("expected header length out of range");

	a_skip_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res_valid |=> skip_q && (pos_q == 6'd0))
		else $error("parser did not return to skipping after a result");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1) && $stable(first_s1))
		else $error("staged byte lost during an output stall");
`endif

endmodule

// ----- rtl/core/ihp_out_reg.sv -----
// Result register between the parser and the output channel.
// Depends on ihp_pkg and ihp_out_if.
`timescale 1ns / 1ps

module ihp_out_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 res_valid,
	input  ihp_pkg::ihp_result_t res,
	output logic                 res_room,
	ihp_out_if.source            res_out
);
	import ihp_pkg::*;

	logic        valid_q;
	ihp_result_t data_q;

	// The register takes a new result when empty or when its content leaves now.
	assign res_room      = !valid_q || res_out.ready;
	assign res_out.valid = valid_q;
	assign res_out.data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_room) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_room && res_valid) begin
			data_q <= res;
		end
	end

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !res_out.ready |=> valid_q && $stable(data_q))
		else $error("pending result overwritten");

	a_room_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_q |-> res_room)
		else $error("empty result register refused a result");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		res_room && res_valid |=> valid_q && (data_q == $past(res)))
		else $error("result not captured");
`endif

endmodule

// ----- rtl/core/ipv4_header_parse_and_checksum.sv -----
// Top level of the IPv4 header parser with header checksum check.
// Depends on ihp_pkg, ihp_in_if, ihp_out_if, ihp_parse and ihp_out_reg.
//
// Channel   Dir   Payload                       Transfer
// hdr_in    in    header_byte, first_byte       valid && ready
// res_out   out   status, fields, checksum      valid && ready
//
// One header byte is taken per cycle; a result passes through the input register,
// then the result register, after the byte that ends or rejects its header.
// The single result register sets the throughput: input stalls only while a
// byte with a result waits behind a full register whose result is not taken.
// Reset clears the handshake state and puts the parser in the wait for a
// first byte; no clearing pass is needed.
`timescale 1ns / 1ps

module ipv4_header_parse_and_checksum #(
	parameter int MAX_OPTION_BYTES = ihp_pkg::DefMaxOptionBytes
) (
	input  logic      clk,
	input  logic      arst_n,
	ihp_in_if.sink    hdr_in,
	ihp_out_if.source res_out
);
	import ihp_pkg::*;

	logic        res_valid;
	logic        res_room;
	ihp_result_t res;

	ihp_parse #(
		.MAX_OPTION_BYTES(MAX_OPTION_BYTES)
	) u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.hdr_in   (hdr_in),
		.res_valid(res_valid),
		.res      (res),
		.res_room (res_room)
	);

	ihp_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_valid(res_valid),
		.res      (res),
		.res_room (res_room),
		.res_out  (res_out)
	);

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the IPv4 header parser with checksum check.
// Depends on ihp_pkg, ihp_in_if, ihp_out_if and ipv4_header_parse_and_checksum.
// A scoreboard class predicts each result from the accepted bytes; plain tasks drive the block.
`timescale 1ns / 1ps

module tb_top;
	import ihp_pkg::*;

	localparam int MaxOptBytes = DefMaxOptionBytes;
	localparam int ByteTarget  = 800;

	// Predicts parse results from accepted header bytes and compares them to the DUT.
	class header_checker;
		int unsigned mismatches;
		int unsigned results_seen;
		int unsigned clean_headers;
		int unsigned rejects;
		int          max_opt;
		bit          waiting_first;
		logic [5:0]  position;
		logic [5:0]  header_len;
		logic [20:0] word_acc;
		logic [7:0]  upper_byte;
		ihp_result_t captured;
		ihp_result_t pending_results[$];

		function new(int max_opt_bytes);
			max_opt       = max_opt_bytes;
			waiting_first = 1'b1;
			position      = '0;
			header_len    = '0;
			word_acc      = '0;
			upper_byte    = '0;
			captured      = '0;
		endfunction

		function void take_byte(ihp_item_t it);
			logic [7:0]  b;
			logic [3:0]  ver;
			int          hlen;
			logic [16:0] fold;
			ihp_result_t r;
			b   = it.header_byte;
			ver = b[7:4];
			if (it.first_byte) begin
				hlen = int'(b[3:0]) * 4;
				if (ver != IpVersion || hlen < BaseHeaderBytes ||
						hlen > BaseHeaderBytes + max_opt) begin
					waiting_first   = 1'b1;
					position        = '0;
					r               = '0;
					r.status        = (ver != IpVersion) ? StatusBadVersion : StatusBadLength;
					r.header_length = hlen[5:0];
					pending_results.push_back(r);
					rejects++;
				end else begin
					waiting_first = 1'b0;
					header_len    = hlen[5:0];
					position      = 6'd1;
					upper_byte    = b;
					word_acc      = '0;
				end
				return;
			end
			if (waiting_first)
				return;
			if (!position[0])
				upper_byte = b;
			else
				word_acc = word_acc + {upper_byte, b};
			case (position)
				6'd1: captured.dscp_ecn = b;
				6'd2, 6'd3: captured.packet_length = {captured.packet_length[7:0], b};
				6'd4, 6'd5: captured.ident_field = {captured.ident_field[7:0], b};
				6'd6, 6'd7: captured.flags_offset = {captured.flags_offset[7:0], b};
				6'd8: captured.hop_limit = b;
				6'd9: captured.proto_number = b;
				6'd10, 6'd11: captured.carried_checksum = {captured.carried_checksum[7:0], b};
				6'd12, 6'd13, 6'd14, 6'd15: captured.src_addr = {captured.src_addr[23:0], b};
				6'd16, 6'd17, 6'd18, 6'd19: captured.dst_addr = {captured.dst_addr[23:0], b};
				default: ;
			endcase
			if (int'(position) + 1 >= int'(header_len)) begin
				// Two end-around folds bring the 21-bit sum back to 16 bits.
				fold              = word_acc[20:16] + word_acc[15:0];
				fold              = fold[16] + fold[15:0];
				r                 = captured;
				r.status          = StatusOk;
				r.header_length   = header_len;
				r.checksum_result = ~fold[15:0];
				pending_results.push_back(r);
				waiting_first     = 1'b1;
				position          = '0;
			end else begin
				position = position + 6'd1;
			end
		endfunction

		function void field_check(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
				mismatches++;
			end
		endfunction

		function void match_result(ihp_result_t got);
			ihp_result_t want;
			if (pending_results.size() == 0) begin
				$display("%0t: result with no expectation, expected none, actual %0h",
					$time, got);
				mismatches++;
				return;
			end
			want = pending_results.pop_front();
			results_seen++;
			field_check("status", want.status, got.status);
			field_check("header_length", want.header_length, got.header_length);
			field_check("dscp_ecn", want.dscp_ecn, got.dscp_ecn);
			field_check("packet_length", want.packet_length, got.packet_length);
			field_check("ident_field", want.ident_field, got.ident_field);
			field_check("flags_offset", want.flags_offset, got.flags_offset);
			field_check("hop_limit", want.hop_limit, got.hop_limit);
			field_check("proto_number", want.proto_number, got.proto_number);
			field_check("carried_checksum", want.carried_checksum, got.carried_checksum);
			field_check("src_addr", want.src_addr, got.src_addr);
			field_check("dst_addr", want.dst_addr, got.dst_addr);
			field_check("checksum_result", want.checksum_result, got.checksum_result);
			if (got.status == StatusOk && got.checksum_result == 16'd0)
				clean_headers++;
		endfunction
	endclass

	logic clk;
	logic arst_n;

	ihp_in_if  hdr_in ();
	ihp_out_if res_out ();

	ipv4_header_parse_and_checksum #(
		.MAX_OPTION_BYTES(MaxOptBytes)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.hdr_in (hdr_in),
		.res_out(res_out)
	);

	header_checker hdr_model;
	int            idle_pct;
	int            hold_left;
	int            bytes_counted;
	bit            hold_done;

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		hdr_in.valid   = 1'b0;
		hdr_in.data    = '0;
		res_out.ready  = 1'b0;
		idle_pct       = 26;
		hold_left      = 0;
		bytes_counted  = 0;
		hold_done      = 1'b0;
		hdr_model      = new(MaxOptBytes);
	end

	always #6 clk = ~clk;

	// Result side: random back-pressure, plus a long hold-off on request.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				res_out.ready <= 1'b0;
			end else begin
				res_out.ready <= ($urandom_range(99) >= idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_out.valid && res_out.ready)
			hdr_model.match_result(res_out.data);
	end

	task automatic send_byte(input logic [7:0] b, input logic first);
		ihp_item_t it;
		it.header_byte = b;
		it.first_byte  = first;
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			hdr_in.valid <= 1'b0;
			@(negedge clk);
		end
		hdr_in.valid <= 1'b1;
		hdr_in.data  <= it;
		@(posedge clk);
		while (!hdr_in.ready)
			@(posedge clk);
		hdr_model.take_byte(it);
	endtask

	task automatic send_run(input logic [7:0] b, input logic first, input int count);
		for (int i = 0; i < count; i++)
			send_byte(b, first && i == 0);
		bytes_counted += count;
	endtask

	// Sends the first cut bytes of a random header; fix_sum makes the checksum valid.
	task automatic send_header(input int ihl, input bit fix_sum, input int cut);
		logic [7:0]  hb [0:59];
		logic [15:0] ck;
		int          hlen;
		int          acc;
		hlen  = ihl * 4;
		hb[0] = {IpVersion, ihl[3:0]};
		for (int i = 1; i < hlen; i++)
			hb[i] = 8'($urandom);
		if (fix_sum) begin
			hb[10] = 8'h00;
			hb[11] = 8'h00;
			acc = 0;
			for (int i = 0; i < hlen; i += 2)
				acc += {hb[i], hb[i + 1]};
			acc = (acc >> 16) + (acc & 32'hFFFF);
			acc = (acc >> 16) + (acc & 32'hFFFF);
			ck = ~acc[15:0];
			hb[10] = ck[15:8];
			hb[11] = ck[7:0];
		end
		for (int i = 0; i < cut; i++)
			send_byte(hb[i], i == 0);
		bytes_counted += cut;
	endtask

	function automatic int pick_ihl();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return 5;
		else if (r < 88)
			return $urandom_range(14, 6);
		return 15;
	endfunction

	function automatic logic [7:0] bad_first_byte();
		logic [7:0] b;
		if ($urandom_range(1)) begin
			b = 8'($urandom);
			if (b[7:4] == IpVersion)
				b[7] = 1'b1;
		end else begin
			b = {IpVersion, 4'($urandom_range(4))};
		end
		return b;
	endfunction

	initial begin
		int kind;
		int ihl;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: unmarked byte while waiting, both faults at once (version wins),
		// short lengths, a wrong version with a good length, a restart in mid header,
		// then a header whose bytes after the first are all ones.
		send_byte(8'hA5, 1'b0);
		send_run(8'hF3, 1'b1, 1);
		send_run(8'h44, 1'b1, 1);
		send_run(8'h40, 1'b1, 1);
		send_run(8'h55, 1'b1, 1);
		send_run(8'h45, 1'b1, 1);
		send_run(8'h00, 1'b0, 5);
		send_run(8'h45, 1'b1, 1);
		send_run(8'hFF, 1'b0, 19);

		while (bytes_counted < ByteTarget) begin
			idle_pct = (bytes_counted >= 300 && bytes_counted < 450) ? 0 : 26;
			if (!hold_done && bytes_counted >= 550) begin
				// The result side holds off while bytes keep coming, so the block fills.
				hold_done = 1'b1;
				hold_left = 400;
				for (int i = 0; i < 8; i++)
					send_run(bad_first_byte(), 1'b1, 1);
				send_header(5, 1'b1, 20);
			end
			kind = $urandom_range(99);
			if (kind < 70) begin
				ihl = pick_ihl();
				send_header(ihl, $urandom_range(1), ihl * 4);
			end else if (kind < 80) begin
				ihl = pick_ihl();
				send_header(ihl, 1'b0, $urandom_range(ihl * 4 - 1, 1));
			end else if (kind < 93) begin
				send_run(bad_first_byte(), 1'b1, 1);
			end else begin
				for (int i = $urandom_range(3, 1); i > 0; i--) begin
					// Unmarked bytes count only when they land inside a header.
					if (!hdr_model.waiting_first)
						bytes_counted++;
					send_byte(8'($urandom), 1'b0);
				end
			end
		end

		@(negedge clk);
		hdr_in.valid <= 1'b0;
		while (hdr_model.pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Covered %0d header bytes and %0d results: %0d valid checksums, %0d rejected.",
			bytes_counted, hdr_model.results_seen, hdr_model.clean_headers, hdr_model.rejects);
		if (hdr_model.mismatches == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

	initial begin
		#2400000;
		$display("Timeout with %0d results still expected.", hdr_model.pending_results.size());
		$display("tb_top: done, errors");
		$finish;
	end

endmodule
